// File: hdl/rce_pkg.sv
// Package for the Roberts cross edge stream block: item types, queue entry type,
// geometry constants and the dimension clamp function. No dependencies.
`timescale 1ns / 1ps

package rce_pkg;

  localparam int unsigned CHAN_W  = 8;   // one color channel
  localparam int unsigned SUM_W   = 10;  // sum of three channels, 0..765
  localparam int unsigned MAG_W   = 11;  // magnitude, 0..1530
  localparam int unsigned COORD_W = 11;  // column and row fields of a result
  localparam int unsigned CFG_W   = 12;  // width of a geometry register
  localparam int unsigned DIM_W   = 14;  // clamped geometry and counter compares
  localparam int unsigned QDEPTH  = 4;   // entries in the front to back queue
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QCNT_W  = 3;

  localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;
  localparam logic [DIM_W-1:0] MIN_DIM      = 14'd3;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [MAG_W-1:0]   magnitude;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               last_of_frame;
  } out_item_t;

  // One interior pixel with its four neighborhood sums, ready for the back end.
  typedef struct packed {
    logic [SUM_W-1:0]   cur;
    logic [SUM_W-1:0]   up;
    logic [SUM_W-1:0]   left;
    logic [SUM_W-1:0]   upper_left;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               last;
  } q_item_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } q_stat_t;

  // Saturate a programmed dimension into 3..hi.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] vx;
    vx = DIM_W'(v);
    if (vx < MIN_DIM) begin
      return MIN_DIM;
    end else if (vx > hi) begin
      return hi;
    end
    return vx;
  endfunction

endpackage

// File: hdl/rce_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read returns the old contents when the same address is written in that cycle.
`timescale 1ns / 1ps

module rce_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rce_front.sv
// Front end: accepts pixels, sums channels, tracks raster position, reads and
// writes the line store and forwards interior pixels to the queue. Uses rce_pkg, rce_ram.
`timescale 1ns / 1ps

module rce_front
  import rce_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048,
  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  in_item_t          in_item_i,
  output logic              in_ready_o,
  input  logic [DIM_W-1:0]  width_i,
  input  logic [DIM_W-1:0]  height_i,
  input  q_stat_t           q_stat_i,
  output logic              push_o,
  output q_item_t           push_item_o,
  output logic              busy_o
);

  logic              accept;
  logic [SUM_W-1:0]  cur;
  logic [SUM_W-1:0]  up;
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [DIM_W-1:0]  col_x, row_x, col_nx, row_nx;
  logic              emit, last;

  logic                s1_valid_q;
  logic [SUM_W-1:0]    s1_cur_q;
  logic [COORD_W-1:0]  s1_col_q, s1_row_q;
  logic                s1_emit_q, s1_last_q;
  logic [SUM_W-1:0]    left_q, ul_q;

  // Credit check: every item in flight is given a queue slot up front.
  assign in_ready_o = (QCNT_W'(q_stat_i.count) + QCNT_W'(s1_valid_q)) < QCNT_W'(QDEPTH);
  assign accept     = in_valid_i && in_ready_o;
  assign busy_o     = s1_valid_q;

  assign cur = SUM_W'(in_item_i.red) + SUM_W'(in_item_i.green) + SUM_W'(in_item_i.blue);

  rce_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (cur),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (up)
  );

  always_comb begin
    col_x  = DIM_W'(col_q);
    row_x  = DIM_W'(row_q);
    col_nx = col_x + 1'b1;
    row_nx = row_x + 1'b1;
    emit   = (row_x >= 14'd1) && (row_x <= height_i - 14'd2) &&
             (col_x >= 14'd1) && (col_x <= width_i - 14'd2);
    last   = (row_x == height_i - 14'd2) && (col_x == width_i - 14'd2);
    col_d  = col_q;
    row_d  = row_q;
    if (accept) begin
      if (col_nx >= width_i) begin
        col_d = '0;
        row_d = (row_nx >= height_i) ? '0 : row_nx[RW-1:0];
      end else begin
        col_d = col_nx[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      left_q     <= '0;
      ul_q       <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= accept;
      if (s1_valid_q) begin
        left_q <= s1_cur_q;
        ul_q   <= up;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cur_q  <= cur;
      s1_col_q  <= col_x[COORD_W-1:0];
      s1_row_q  <= row_x[COORD_W-1:0];
      s1_emit_q <= emit;
      s1_last_q <= last;
    end
  end

  assign push_o                 = s1_valid_q && s1_emit_q;
  assign push_item_o.cur        = s1_cur_q;
  assign push_item_o.up         = up;
  assign push_item_o.left       = left_q;
  assign push_item_o.upper_left = ul_q;
  assign push_item_o.column     = s1_col_q;
  assign push_item_o.row        = s1_row_q;
  assign push_item_o.last       = s1_last_q;

endmodule

// File: hdl/rce_queue.sv
// Short register queue between the front and back ends.
// Depends on rce_pkg for the entry type and depth.
`timescale 1ns / 1ps

module rce_queue
  import rce_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_item_t  push_item_i,
  input  logic     pop_i,
  output logic     valid_o,
  output q_item_t  pop_item_o,
  output q_stat_t  stat_o
);

  q_item_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_pop;

  assign valid_o    = (cnt_q != '0);
  assign do_pop     = pop_i && valid_o;
  assign pop_item_o = mem_q[rd_q];

  assign stat_o.count = cnt_q;
  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = !valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

// File: hdl/rce_back.sv
// Back end: computes the Roberts magnitude of a queued pixel and holds the
// result in the output register. Depends on rce_pkg.
`timescale 1ns / 1ps

module rce_back
  import rce_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  q_item_t   q_item_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic [SUM_W-1:0] diff_a, diff_b;
  logic             out_valid_q;
  out_item_t        out_q, out_d;

  always_comb begin
    diff_a = (q_item_i.upper_left > q_item_i.cur) ? q_item_i.upper_left - q_item_i.cur
                                                   : q_item_i.cur - q_item_i.upper_left;
    diff_b = (q_item_i.up > q_item_i.left) ? q_item_i.up - q_item_i.left
                                           : q_item_i.left - q_item_i.up;
    out_d.magnitude     = MAG_W'(diff_a) + MAG_W'(diff_b);
    out_d.column        = q_item_i.column;
    out_d.row           = q_item_i.row;
    out_d.last_of_frame = q_item_i.last;
  end

  assign pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: hdl/roberts_cross_edge_stream.sv
// Top level of the Roberts cross edge detector on an RGB pixel stream.
// Depends on rce_pkg, rce_front, rce_queue, rce_back and rce_ram.
//
// Usage: pixels enter in raster order on the in_ channel (valid/ready), one
// item per pixel. Each pixel's three channels are summed; for every interior
// pixel (row 1..height-2, column 1..width-2) one item leaves on the out_
// channel with |upper-left - current| + |upper - left|, its column, its row
// and a flag on the last interior pixel of the frame. Border pixels are
// consumed and produce nothing.
// Throughput is one pixel per clock while in_ready_o is high. The line store
// is a single RAM that is read and written at the current column in the
// acceptance cycle. A result passes from the line store read at acceptance
// through a queue write to the output register.
// When the receiver stalls, the output register holds its item, the four
// entry queue fills, and in_ready_o drops once every slot is spoken for; no
// item is lost. After reset the geometry is 640 x 480, the position counters
// and neighbor sums are zero, and the line store holds whatever it held: the
// first row of a frame never reads it for a result.
// Geometry registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// while the block is idle; values outside 3..MAX are saturated.
`timescale 1ns / 1ps

module roberts_cross_edge_stream
  import rce_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  logic [CFG_W-1:0] width_q, height_q;
  logic [DIM_W-1:0] width_eff, height_eff;
  logic             push, pop, q_valid, front_busy;
  q_item_t          push_item, pop_item;
  q_stat_t          q_stat;

  // Geometry registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign width_eff  = clamp_dim(width_q, DIM_W'(MAX_WIDTH));
  assign height_eff = clamp_dim(height_q, DIM_W'(MAX_HEIGHT));

  rce_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_ready_o  (in_ready_o),
    .width_i     (width_eff),
    .height_i    (height_eff),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_item_o (push_item),
    .busy_o      (front_busy)
  );

  rce_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item),
    .stat_o      (q_stat)
  );

  rce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // The credit check must keep the queue from ever being written while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_stat.full)
    else $error("queue written while full");

  // Backpressure on the input only comes from work already inside the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !in_ready_o |-> (front_busy || !q_stat.empty))
    else $error("input stalled with nothing in flight");

  // Two absolute differences of 10-bit sums cannot exceed 1530.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o |-> (out_item_o.magnitude <= 11'd1530))
    else $error("magnitude out of range");

endmodule

// File: tb/sv/rce_checker.sv
// Scoreboard for the Roberts cross edge stream: watches the pixel, result and geometry ports,
// predicts every interior-pixel result and compares it with what the block delivers.
// Depends on rce_pkg for the item types, widths and register indexes.
`timescale 1ns / 1ps

module rce_checker
  import rce_pkg::*;
#(
  parameter int unsigned MAX_W = 2048,
  parameter int unsigned MAX_H = 2048
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  in_item_t         in_item_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  out_item_t        out_item_i,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output int unsigned      error_count_o,
  output int unsigned      pending_o,
  output int unsigned      checked_o,
  output logic             at_origin_o
);

  localparam int unsigned PRINT_CAP = 200;

  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;
  bit   [SUM_W-1:0]   row_above [MAX_W];
  logic [SUM_W-1:0]   left_sum;
  logic [SUM_W-1:0]   upper_left_sum;
  logic [COORD_W-1:0] col_pos;
  logic [COORD_W-1:0] row_pos;
  out_item_t          edge_q [$];

  function automatic int unsigned eff_dim(logic [CFG_W-1:0] raw, int unsigned hi);
    if (raw < 3) begin
      return 3;
    end
    if (raw > hi) begin
      return hi;
    end
    return 32'(raw);
  endfunction

  function automatic logic [SUM_W-1:0] sum_gap(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // One accepted pixel: emit the expected result for interior positions, then slide the
  // window and advance the raster position exactly as the block does.
  function automatic void predict_edge(in_item_t px);
    int unsigned w, h, c, r;
    logic [SUM_W-1:0] cur, up;
    out_item_t res;
    w   = eff_dim(width_reg, MAX_W);
    h   = eff_dim(height_reg, MAX_H);
    c   = 32'(col_pos);
    r   = 32'(row_pos);
    cur = SUM_W'(px.red) + SUM_W'(px.green) + SUM_W'(px.blue);
    up  = row_above[col_pos];
    if (r >= 1 && r <= h - 2 && c >= 1 && c <= w - 2) begin
      res.magnitude     = MAG_W'(sum_gap(upper_left_sum, cur)) + MAG_W'(sum_gap(up, left_sum));
      res.column        = COORD_W'(c);
      res.row           = COORD_W'(r);
      res.last_of_frame = (r == h - 2) && (c == w - 2);
      edge_q.push_back(res);
    end
    upper_left_sum     = up;
    left_sum           = cur;
    row_above[col_pos] = cur;
    if (c + 1 >= w) begin
      col_pos = '0;
      row_pos = (r + 1 >= h) ? '0 : COORD_W'(r + 1);
    end else begin
      col_pos = COORD_W'(c + 1);
    end
  endfunction

  function automatic void note_mismatch(string field, int unsigned want, int unsigned got,
                                        logic got_unknown);
    error_count_o++;
    if (error_count_o <= PRINT_CAP) begin
      if (got_unknown) begin
        $display("%0t: %s mismatch: expected %0d, got unknown bits", $time, field, want);
      end else begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      end
    end
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (edge_q.size() == 0) begin
      error_count_o++;
      if (error_count_o <= PRINT_CAP) begin
        $display("%0t: unexpected result: expected none, got mag=%0d col=%0d row=%0d last=%0d",
                 $time, got.magnitude, got.column, got.row, got.last_of_frame);
      end
      return;
    end
    want = edge_q.pop_front();
    checked_o++;
    if (got.magnitude !== want.magnitude) begin
      note_mismatch("magnitude", 32'(want.magnitude), 32'(got.magnitude),
                    $isunknown(got.magnitude));
    end
    if (got.column !== want.column) begin
      note_mismatch("column", 32'(want.column), 32'(got.column), $isunknown(got.column));
    end
    if (got.row !== want.row) begin
      note_mismatch("row", 32'(want.row), 32'(got.row), $isunknown(got.row));
    end
    if (got.last_of_frame !== want.last_of_frame) begin
      note_mismatch("last_of_frame", 32'(want.last_of_frame), 32'(got.last_of_frame),
                    $isunknown(got.last_of_frame));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg      = RESET_WIDTH;
      height_reg     = RESET_HEIGHT;
      left_sum       = '0;
      upper_left_sum = '0;
      col_pos        = '0;
      row_pos        = '0;
      edge_q.delete();
      error_count_o  = 0;
      checked_o      = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_result(out_item_i);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_IMAGE_WIDTH) begin
          width_reg = cfg_wdata_i;
        end else begin
          height_reg = cfg_wdata_i;
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_edge(in_item_i);
      end
    end
    pending_o   = edge_q.size();
    at_origin_o = (col_pos == '0) && (row_pos == '0);
  end

endmodule

// File: tb/sv/tb_top.sv
// Top of the Roberts cross edge stream testbench: clock, reset, pixel stimulus, random
// backpressure and the verdict. Depends on rce_pkg, rce_checker and the block itself.
`timescale 1ns / 1ps

module tb_top;
  import rce_pkg::*;

  // A correct run is about a thousand pixels plus the settling pauses around
  // each geometry write; this limit leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT   = 250_000;
  localparam int unsigned RANDOM_PIXELS = 900;
  localparam int unsigned IDLE_PCT      = 36;
  // The block has a pipeline of stage register, queue and output register; pixels that produce no
  // result may still be in flight when the last expected result has arrived, so wait a bit longer.
  localparam int unsigned SETTLE        = 8;

  localparam in_item_t WHITE = '{red: 8'd255, green: 8'd255, blue: 8'd255};
  localparam in_item_t BLACK = '{red: 8'd0, green: 8'd0, blue: 8'd0};
  localparam in_item_t GRAY  = '{red: 8'd128, green: 8'd64, blue: 8'd32};

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_item;
  logic             cfg_we    = 1'b0;
  logic [0:0]       cfg_idx   = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  int unsigned error_count;
  int unsigned pending;
  int unsigned checked;
  logic        at_origin;

  // When set, neither side idles: the pixel source sends back to back and the
  // result sink is always ready.
  bit          steady      = 1'b0;
  int unsigned pixels_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  roberts_cross_edge_stream i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  rce_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_item_i    (out_item),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .error_count_o (error_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .at_origin_o   (at_origin)
  );

  // The result sink stalls in about a third of the cycles, independent of the
  // pixel side, so stalls land on every phase of the pipeline.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Channel values lean toward the extremes so that sums of 0 and 765 show up often.
  function automatic logic [CHAN_W-1:0] chan_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom_range(255));
    endcase
  endfunction

  function automatic in_item_t random_pixel();
    in_item_t px;
    px.red   = chan_value();
    px.green = chan_value();
    px.blue  = chan_value();
    return px;
  endfunction

  // Present one pixel, with a random gap in front unless the run is in its steady
  // stretch. Called and returns at a falling edge. Valid is only lowered during a
  // gap, so back to back pixels keep it high.
  task automatic push_pixel(input in_item_t px);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= px;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    pixels_sent++;
  endtask

  // Geometry is only written with the pipeline drained: every expected result has
  // come back and a settling pause has passed for pixels that produce none.
  task automatic write_geometry(input logic [0:0] idx, input logic [CFG_W-1:0] data);
    in_valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random pixels until the raster position is back at the top left corner.
  task automatic finish_frame();
    while (!at_origin) begin
      push_pixel(random_pixel());
    end
    frames_sent++;
  endtask

  initial begin
    int unsigned w_raw, h_raw, eff_w, eff_h, cut, random_stop;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Smallest frame, reached through below-range values that saturate to 3 x 3.
    // The single interior pixel sees white above and black on its own row, which
    // gives the largest possible magnitude and flags the end of the frame.
    write_geometry(REG_IMAGE_WIDTH, CFG_W'(0));
    write_geometry(REG_IMAGE_HEIGHT, CFG_W'(2));
    push_pixel(WHITE);
    push_pixel(WHITE);
    push_pixel(random_pixel());
    push_pixel(BLACK);
    push_pixel(BLACK);
    finish_frame();

    // A 5 x 5 frame whose first two rows are flat, so the first interior results are
    // zero. Partway into row 2, at column 3, the frame shrinks to 3 x 4: that pixel now
    // lies beyond the last column, produces nothing and wraps into the last row.
    write_geometry(REG_IMAGE_WIDTH, CFG_W'(5));
    write_geometry(REG_IMAGE_HEIGHT, CFG_W'(5));
    repeat (10) push_pixel(GRAY);
    repeat (3) push_pixel(random_pixel());
    write_geometry(REG_IMAGE_WIDTH, CFG_W'(3));
    write_geometry(REG_IMAGE_HEIGHT, CFG_W'(4));
    finish_frame();

    // Random frames of mostly small geometry. Width only grows at a frame boundary,
    // where the first row refills the line store before any result reads it; within
    // a frame it may only shrink, so no never-written line store entry is ever used.
    random_stop = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < random_stop) begin
      case ($urandom_range(9))
        0: begin
          w_raw = $urandom_range(2);
          h_raw = $urandom_range(3, 8);
        end
        1: begin
          w_raw = $urandom_range(3, 12);
          h_raw = $urandom_range(2);
        end
        2: begin
          w_raw = $urandom_range(13, 40);
          h_raw = $urandom_range(3, 5);
        end
        default: begin
          w_raw = $urandom_range(3, 12);
          h_raw = $urandom_range(3, 8);
        end
      endcase
      eff_w = (w_raw < 3) ? 3 : w_raw;
      eff_h = (h_raw < 3) ? 3 : h_raw;
      write_geometry(REG_IMAGE_WIDTH, CFG_W'(w_raw));
      write_geometry(REG_IMAGE_HEIGHT, CFG_W'(h_raw));

      // A handful of frames early in the random stretch run with no idling on
      // either side.
      steady = (frames_sent >= 6) && (frames_sent < 12);

      if ($urandom_range(4) == 0) begin
        // Change the geometry partway through the frame.
        cut = $urandom_range(1, eff_w * eff_h - 1);
        repeat (cut) push_pixel(random_pixel());
        if ($urandom_range(1) == 1) begin
          eff_w = $urandom_range(3, eff_w);
          write_geometry(REG_IMAGE_WIDTH, CFG_W'(eff_w));
        end else begin
          write_geometry(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(3, 10)));
        end
      end else begin
        push_pixel(random_pixel());
      end
      finish_frame();
    end
    steady = 1'b0;

    // The largest width and the largest height, each reached through an above-range value that saturates.
    // Each frame runs well past every smaller limit and is then cut short by shrinking
    // the geometry, which wraps the raster position without streaming a full frame.
    write_geometry(REG_IMAGE_WIDTH, CFG_W'(4095));
    write_geometry(REG_IMAGE_HEIGHT, CFG_W'(0));
    repeat (60) push_pixel(random_pixel());
    write_geometry(REG_IMAGE_WIDTH, CFG_W'(3));
    finish_frame();
    write_geometry(REG_IMAGE_WIDTH, CFG_W'(1));
    write_geometry(REG_IMAGE_HEIGHT, CFG_W'(2049));
    repeat (60) push_pixel(random_pixel());
    write_geometry(REG_IMAGE_HEIGHT, CFG_W'(3));
    finish_frame();

    // Drain: wait for every outstanding result, then a little longer so that any
    // spurious late result would still be caught.
    in_valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (4 * SETTLE) @(negedge clk);

    $display("Streamed %0d pixels in %0d frames, from saturated 3 x 3 up to the saturated",
             pixels_sent, frames_sent);
    $display("2048 limits, with mid-frame geometry changes; %0d edge results compared.",
             checked);
    if (error_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/rce_pkg.sv
hdl/rce_ram.sv
hdl/rce_front.sv
hdl/rce_queue.sv
hdl/rce_back.sv
hdl/roberts_cross_edge_stream.sv
tb/sv/rce_checker.sv
tb/sv/tb_top.sv
